// ===== rtl/crc_pkg.sv =====
// Shared widths, pipeline stage record and saturation helper for the collision response block.
`default_nettype none
package crc_pkg;

    // Quotient bits of the velocity correction divide (magnitude below 2^18).
    localparam int Q_W    = 18;
    // Partial remainder of the divide: 4*|v.d*d| + |d|^2 stays below 2^39.
    localparam int REM_W  = 40;
    // Push-out offset magnitude, one spare bit for the rounding increment.
    localparam int M_W    = 12;
    // Square of a trial offset (below 2^22).
    localparam int M2_W   = 22;
    // Squared distance (sum of two squares of 10 bit values).
    localparam int D2_W   = 21;
    // Square of one distance component or of the radius.
    localparam int SQ_W   = 20;
    // Comparison target |d|^2 * r^2 for one axis.
    localparam int TGT_W  = 40;
    // Positions on the rectangle, with room for the far edge.
    localparam int PT_W   = 18;
    // Number of bit steps of the offset search.
    localparam int SQ_STEPS = M_W - 1;

    typedef struct packed {
        logic [M_W-1:0]  m;
        logic [M2_W-1:0] m2;
    } sq_t;

    typedef struct packed {
        logic                   hit;
        logic                   live;
        logic signed [15:0]     vx;
        logic signed [15:0]     vy;
        logic signed [15:0]     cx;
        logic signed [15:0]     cy;
        logic signed [PT_W-1:0] px;
        logic signed [PT_W-1:0] py;
        logic                   xneg;
        logic                   yneg;
        logic                   cnx;
        logic                   cny;
        logic [D2_W-1:0]        d2;
        logic [TGT_W-1:0]       tx;
        logic [TGT_W-1:0]       ty;
        logic [REM_W-1:0]       remx;
        logic [REM_W-1:0]       remy;
        logic [Q_W-1:0]         qx;
        logic [Q_W-1:0]         qy;
        sq_t                    sx;
        sq_t                    sy;
    } stage_t;

    function automatic logic signed [15:0] sat16(input logic signed [19:0] v);
        logic signed [15:0] res;
        if (v > 20'sd32767)
        begin
            res = 16'sh7FFF;
        end
        else if (v < -20'sd32768)
        begin
            res = 16'sh8000;
        end
        else
        begin
            res = v[15:0];
        end
        return res;
    endfunction

endpackage
`default_nettype wire

// ===== rtl/crc_if.sv =====
// Stream interfaces for circle/rectangle items and collision results.
`default_nettype none
interface crc_in_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] ball_x;
    logic signed [15:0] ball_y;
    logic signed [15:0] ball_vx;
    logic signed [15:0] ball_vy;
    logic [9:0]         ball_radius;
    logic signed [15:0] rect_x;
    logic signed [15:0] rect_y;
    logic [14:0]        rect_width;
    logic [14:0]        rect_height;
    logic               rect_active;

    modport source (output valid, ball_x, ball_y, ball_vx, ball_vy, ball_radius, rect_x,
                    rect_y, rect_width, rect_height, rect_active, input ready);
    modport sink (input valid, ball_x, ball_y, ball_vx, ball_vy, ball_radius, rect_x,
                  rect_y, rect_width, rect_height, rect_active, output ready);
endinterface

interface crc_out_if;
    logic               valid;
    logic               ready;
    logic               hit;
    logic signed [15:0] new_vx;
    logic signed [15:0] new_vy;
    logic signed [15:0] new_x;
    logic signed [15:0] new_y;

    modport source (output valid, hit, new_vx, new_vy, new_x, new_y, input ready);
    modport sink (input valid, hit, new_vx, new_vy, new_x, new_y, output ready);
endinterface
`default_nettype wire

// ===== rtl/crc_step.sv =====
// One step: one quotient bit of both divides; early steps also step both offset searches.
`default_nettype none
module crc_step #(
    parameter int STEP = 0
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            en,
    input  wire logic            in_valid,
    input  wire crc_pkg::stage_t in_data,
    output logic                 out_valid,
    output crc_pkg::stage_t      out_data
);
    import crc_pkg::*;

    localparam int DK = Q_W - 1 - STEP;
    localparam int SK = (STEP < SQ_STEPS) ? (SQ_STEPS - 1 - STEP) : 0;
    localparam int PW = M2_W + D2_W;
    localparam int RW = M2_W + 2 + D2_W;

    logic [REM_W-1:0] dsh;
    stage_t           nxt;
    logic             valid_reg;
    stage_t           data_reg;

    // Trial of one offset bit: keep it when (m + bit)^2 * d2 stays within the target.
    function automatic sq_t sq_bit(input sq_t cur, input logic [D2_W-1:0] d2,
                                   input logic [TGT_W-1:0] tgt);
        sq_t             res;
        logic [M2_W-1:0] t2;
        logic [PW-1:0]   prod;
        res  = cur;
        t2   = cur.m2 + (M2_W'(cur.m) << (SK + 1)) + (M2_W'(1) << (2 * SK));
        prod = PW'(t2) * PW'(d2);
        if (prod <= PW'(tgt))
        begin
            res.m  = cur.m + (M_W'(1) << SK);
            res.m2 = t2;
        end
        return res;
    endfunction

    // Round to nearest: step up when (2m+1)^2 * d2 is within four times the target.
    function automatic sq_t sq_round(input sq_t cur, input logic [D2_W-1:0] d2,
                                     input logic [TGT_W-1:0] tgt);
        sq_t               res;
        logic [M2_W+1:0]   s;
        logic [RW-1:0]     prod;
        res  = cur;
        s    = ((M2_W + 2)'(cur.m2) << 2) + ((M2_W + 2)'(cur.m) << 2) + (M2_W + 2)'(1);
        prod = RW'(s) * RW'(d2);
        if (prod <= (RW'(tgt) << 2))
        begin
            res.m = cur.m + M_W'(1);
        end
        return res;
    endfunction

    assign dsh = REM_W'({in_data.d2, 1'b0}) << DK;

    always_comb
    begin
        nxt = in_data;
        if (in_data.remx >= dsh)
        begin
            nxt.remx     = in_data.remx - dsh;
            nxt.qx[DK]   = 1'b1;
        end
        if (in_data.remy >= dsh)
        begin
            nxt.remy     = in_data.remy - dsh;
            nxt.qy[DK]   = 1'b1;
        end
        if (STEP < SQ_STEPS)
        begin
            nxt.sx = sq_bit(in_data.sx, in_data.d2, in_data.tx);
            nxt.sy = sq_bit(in_data.sy, in_data.d2, in_data.ty);
        end
        else if (STEP == SQ_STEPS)
        begin
            nxt.sx = sq_round(in_data.sx, in_data.d2, in_data.tx);
            nxt.sy = sq_round(in_data.sy, in_data.d2, in_data.ty);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= nxt;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule
`default_nettype wire

// ===== rtl/circle_rect_collision_response.sv =====
// Top level of the circle against rectangle collision test and response pipeline.
//
// Usage: each transfer on in_ch carries one circle (center, velocity, radius) and one
// axis-aligned rectangle with its active flag. Each produces exactly one transfer on
// out_ch with the hit flag and the new velocity and center, in input order.
// Throughput is one item per cycle while out_ch is not stalled: a new item may be accepted in every such cycle.
// On its way from acceptance to out_ch an item passes four front stages (clamp,
// squares and products, sums and targets, divide numerators), eighteen steps that
// each resolve one quotient bit of the velocity divide and, in the first eleven, one
// bit of the push-out offset search (the twelfth rounds it), and the output register.
// The whole pipeline advances together. When out_ch holds a result that the receiver
// does not take, every stage holds and in_ch.ready drops, so nothing is lost or
// repeated; ready returns in the cycle the result is taken.
// Reset clears all valid bits, so the block comes out of reset empty and ready.
// A circle of nonzero radius whose center lies on or inside an active rectangle reports
// a hit with velocity and center unchanged.
`default_nettype none
module circle_rect_collision_response (
    input  wire logic clk,
    input  wire logic rst_n,
    crc_in_if.sink    in_ch,
    crc_out_if.source out_ch
);
    import crc_pkg::*;

    localparam int PV_W = 27;
    localparam int VD_W = 28;
    localparam int W_W  = 39;

    logic en;

    // Stage 1: closest point and distance vector.
    logic                   v1_reg;
    logic signed [15:0]     cx1_reg, cy1_reg, vx1_reg, vy1_reg;
    logic [9:0]             r1_reg;
    logic                   act1_reg;
    logic signed [PT_W-1:0] px1_reg, py1_reg, dx1_reg, dy1_reg;
    logic signed [PT_W-1:0] px_next, py_next, dx_next, dy_next;

    // Stage 2: squares and velocity products.
    logic                   v2_reg;
    logic signed [15:0]     cx2_reg, cy2_reg, vx2_reg, vy2_reg;
    logic signed [PT_W-1:0] px2_reg, py2_reg;
    logic                   ok2_reg;
    logic [SQ_W-1:0]        ax2_reg, ay2_reg, r2_reg;
    logic signed [PV_W-1:0] pvx_reg, pvy_reg;
    logic signed [10:0]     dx2_reg, dy2_reg;
    logic [PT_W-1:0]        adx, ady;

    // Stage 3: squared distance, hit test, dot product and offset targets.
    logic                   v3_reg;
    logic signed [15:0]     cx3_reg, cy3_reg, vx3_reg, vy3_reg;
    logic signed [PT_W-1:0] px3_reg, py3_reg;
    logic                   hit3_reg, live3_reg;
    logic [D2_W-1:0]        d2_reg;
    logic signed [VD_W-1:0] vd_reg;
    logic [TGT_W-1:0]       tx_reg, ty_reg;
    logic signed [10:0]     dx3_reg, dy3_reg;
    logic [D2_W-1:0]        d2_next;

    // Stage 4 and the stepping pipeline.
    logic                   v4_reg;
    stage_t                 s4_reg;
    stage_t                 s4_next;
    logic signed [W_W-1:0]  wx, wy;
    logic [W_W-1:0]         mwx, mwy;
    logic                   pv   [Q_W+1];
    stage_t                 pd   [Q_W+1];

    // Output register.
    logic                   out_valid_reg;
    logic                   out_hit_reg;
    logic signed [15:0]     out_vx_reg, out_vy_reg, out_x_reg, out_y_reg;
    logic signed [19:0]     corr_x, corr_y, offs_x, offs_y;
    stage_t                 fin;

    assign en          = !out_valid_reg || out_ch.ready;
    assign in_ch.ready = en;

    // Clamp the center onto the rectangle; the far edge is formed at full width.
    always_comb
    begin
        logic signed [PT_W-1:0] cxw, cyw, rxw, ryw, rxh, ryh;
        cxw = PT_W'(in_ch.ball_x);
        cyw = PT_W'(in_ch.ball_y);
        rxw = PT_W'(in_ch.rect_x);
        ryw = PT_W'(in_ch.rect_y);
        rxh = rxw + $signed({3'b000, in_ch.rect_width});
        ryh = ryw + $signed({3'b000, in_ch.rect_height});
        px_next = (cxw > rxh) ? rxh : cxw;
        px_next = (px_next < rxw) ? rxw : px_next;
        py_next = (cyw > ryh) ? ryh : cyw;
        py_next = (py_next < ryw) ? ryw : py_next;
        dx_next = cxw - px_next;
        dy_next = cyw - py_next;
    end

    assign adx = dx1_reg[PT_W-1] ? PT_W'(-dx1_reg) : PT_W'(dx1_reg);
    assign ady = dy1_reg[PT_W-1] ? PT_W'(-dy1_reg) : PT_W'(dy1_reg);

    assign d2_next = D2_W'(ax2_reg) + D2_W'(ay2_reg);

    // Divide numerators: round(2 v.d dx / d2) becomes floor((4|v.d dx| + d2) / 2 d2).
    assign wx  = W_W'(vd_reg) * W_W'(dx3_reg);
    assign wy  = W_W'(vd_reg) * W_W'(dy3_reg);
    assign mwx = wx[W_W-1] ? W_W'(-wx) : W_W'(wx);
    assign mwy = wy[W_W-1] ? W_W'(-wy) : W_W'(wy);

    always_comb
    begin
        s4_next      = '0;
        s4_next.hit  = hit3_reg;
        s4_next.live = live3_reg;
        s4_next.vx   = vx3_reg;
        s4_next.vy   = vy3_reg;
        s4_next.cx   = cx3_reg;
        s4_next.cy   = cy3_reg;
        s4_next.px   = px3_reg;
        s4_next.py   = py3_reg;
        s4_next.xneg = dx3_reg[10];
        s4_next.yneg = dy3_reg[10];
        s4_next.cnx  = wx[W_W-1];
        s4_next.cny  = wy[W_W-1];
        s4_next.d2   = d2_reg;
        s4_next.tx   = tx_reg;
        s4_next.ty   = ty_reg;
        s4_next.remx = (REM_W'(mwx) << 2) + REM_W'(d2_reg);
        s4_next.remy = (REM_W'(mwy) << 2) + REM_W'(d2_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg        <= in_ch.valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= pv[Q_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            cx1_reg  <= in_ch.ball_x;
            cy1_reg  <= in_ch.ball_y;
            vx1_reg  <= in_ch.ball_vx;
            vy1_reg  <= in_ch.ball_vy;
            r1_reg   <= in_ch.ball_radius;
            act1_reg <= in_ch.rect_active;
            px1_reg  <= px_next;
            py1_reg  <= py_next;
            dx1_reg  <= dx_next;
            dy1_reg  <= dy_next;

            // A component of 1024 or more can never be inside a 10 bit radius.
            cx2_reg  <= cx1_reg;
            cy2_reg  <= cy1_reg;
            vx2_reg  <= vx1_reg;
            vy2_reg  <= vy1_reg;
            px2_reg  <= px1_reg;
            py2_reg  <= py1_reg;
            ok2_reg  <= act1_reg && (adx[PT_W-1:10] == '0) && (ady[PT_W-1:10] == '0);
            ax2_reg  <= SQ_W'(adx[9:0]) * SQ_W'(adx[9:0]);
            ay2_reg  <= SQ_W'(ady[9:0]) * SQ_W'(ady[9:0]);
            r2_reg   <= SQ_W'(r1_reg) * SQ_W'(r1_reg);
            pvx_reg  <= PV_W'(vx1_reg) * PV_W'($signed(dx1_reg[10:0]));
            pvy_reg  <= PV_W'(vy1_reg) * PV_W'($signed(dy1_reg[10:0]));
            dx2_reg  <= dx1_reg[10:0];
            dy2_reg  <= dy1_reg[10:0];

            cx3_reg   <= cx2_reg;
            cy3_reg   <= cy2_reg;
            vx3_reg   <= vx2_reg;
            vy3_reg   <= vy2_reg;
            px3_reg   <= px2_reg;
            py3_reg   <= py2_reg;
            hit3_reg  <= ok2_reg && (d2_next < D2_W'(r2_reg));
            live3_reg <= ok2_reg && (d2_next < D2_W'(r2_reg)) && (d2_next != '0);
            d2_reg    <= d2_next;
            vd_reg    <= VD_W'(pvx_reg) + VD_W'(pvy_reg);
            tx_reg    <= TGT_W'(ax2_reg) * TGT_W'(r2_reg);
            ty_reg    <= TGT_W'(ay2_reg) * TGT_W'(r2_reg);
            dx3_reg   <= dx2_reg;
            dy3_reg   <= dy2_reg;

            s4_reg    <= s4_next;
        end
    end

    assign pv[0] = v4_reg;
    assign pd[0] = s4_reg;

    for (genvar g = 0; g < Q_W; g++)
    begin : g_step
        crc_step #(.STEP(g)) u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (en),
            .in_valid  (pv[g]),
            .in_data   (pd[g]),
            .out_valid (pv[g+1]),
            .out_data  (pd[g+1])
        );
    end

    // Apply the correction and the offset, saturate; pass through unless there is a hit with a normal.
    assign fin    = pd[Q_W];
    assign corr_x = fin.cnx ? -$signed({2'b00, fin.qx}) : $signed({2'b00, fin.qx});
    assign corr_y = fin.cny ? -$signed({2'b00, fin.qy}) : $signed({2'b00, fin.qy});
    assign offs_x = fin.xneg ? -$signed(20'(fin.sx.m)) : $signed(20'(fin.sx.m));
    assign offs_y = fin.yneg ? -$signed(20'(fin.sy.m)) : $signed(20'(fin.sy.m));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_hit_reg <= fin.hit;
            if (fin.live)
            begin
                out_vx_reg <= sat16(20'(fin.vx) - corr_x);
                out_vy_reg <= sat16(20'(fin.vy) - corr_y);
                out_x_reg  <= sat16(20'(fin.px) + offs_x);
                out_y_reg  <= sat16(20'(fin.py) + offs_y);
            end
            else
            begin
                out_vx_reg <= fin.vx;
                out_vy_reg <= fin.vy;
                out_x_reg  <= fin.cx;
                out_y_reg  <= fin.cy;
            end
        end
    end

    assign out_ch.valid  = out_valid_reg;
    assign out_ch.hit    = out_hit_reg;
    assign out_ch.new_vx = out_vx_reg;
    assign out_ch.new_vy = out_vy_reg;
    assign out_ch.new_x  = out_x_reg;
    assign out_ch.new_y  = out_y_reg;

    // A held output freezes the front of the pipeline.
    a_hold_front: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> $stable(v1_reg) && $stable(v4_reg))
        else $error("pipeline front moved while the output was stalled");

    // An accepted item enters the first stage.
    a_enter: assert property (@(posedge clk) disable iff (!rst_n)
        in_ch.valid && in_ch.ready |=> v1_reg)
        else $error("accepted item did not enter the pipeline");

    // The last step hands its item to the output register when the pipeline advances.
    a_leave: assert property (@(posedge clk) disable iff (!rst_n)
        pv[Q_W] && en |=> out_valid_reg)
        else $error("finished item did not reach the output register");

endmodule
`default_nettype wire
